>>> rtl/core/tnnm_pkg.sv
// ----------------------------------------------------------------------------
// Nearest neighbor match package
// Shared field widths, codes, state type and control structures.
// ----------------------------------------------------------------------------
package tnnm_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned LABEL_W = 8;
    localparam int unsigned ENTRY_W = 6;
    localparam int unsigned ELEM_W  = 7;
    localparam int unsigned DIST_W  = 39;
    localparam int unsigned ACTIVE_W = 7;
    localparam int unsigned SQ_W    = 32;
    localparam int unsigned IDX_W   = 16;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 39;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 1'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 39'd96636764;
    localparam logic [DIST_W-1:0] DIST_MAX        = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic start;
        logic issue;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic issue_last;
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/core/tnnm_ctrl.sv
// ----------------------------------------------------------------------------
// Nearest neighbor match controller
// Sequences item intake, the distance sweep, pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
module tnnm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_search,
    output logic              o_ready,
    output tnnm_pkg::t_dp_cmd o_cmd,
    input  tnnm_pkg::t_dp_sts i_sts
);

    tnnm_pkg::t_state r_state;
    tnnm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tnnm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tnnm_pkg::S_IDLE: begin
                if (i_valid && i_search) begin
                    n_state = i_sts.count_zero ? tnnm_pkg::S_DONE : tnnm_pkg::S_RUN;
                end
            end
            tnnm_pkg::S_RUN: begin
                if (i_sts.issue_last) begin
                    n_state = tnnm_pkg::S_DRAIN;
                end
            end
            tnnm_pkg::S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = tnnm_pkg::S_DONE;
                end
            end
            tnnm_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = tnnm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tnnm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            tnnm_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.take  = i_valid;
                o_cmd.start = i_valid && i_search;
            end
            tnnm_pkg::S_RUN: begin
                o_cmd.issue = 1'b1;
            end
            tnnm_pkg::S_DONE: begin
                o_cmd.publish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/tnnm_datapath.sv
// ----------------------------------------------------------------------------
// Nearest neighbor match datapath
// Stores, configuration, subtract-square-accumulate pipeline and result register.
// ----------------------------------------------------------------------------
module tnnm_datapath #(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned DIM     = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tnnm_pkg::t_dp_cmd                   i_cmd,
    output tnnm_pkg::t_dp_sts                   o_sts,
    input  logic                                i_cfg_we,
    input  logic [tnnm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tnnm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_item_cmd,
    input  logic [tnnm_pkg::ENTRY_W-1:0]        i_entry_index,
    input  logic [tnnm_pkg::ELEM_W-1:0]         i_element_index,
    input  logic signed [tnnm_pkg::VALUE_W-1:0] i_element_value,
    input  logic [tnnm_pkg::LABEL_W-1:0]        i_entry_label,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_found,
    output logic [tnnm_pkg::LABEL_W-1:0]        o_match_label,
    output logic [tnnm_pkg::DIST_W-1:0]         o_best_distance_sq
);

    localparam int unsigned EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned DW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int unsigned DEPTH = ENTRIES * DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [DW-1:0] ELE_LAST = DW'(DIM - 1);

    logic [tnnm_pkg::VALUE_W-1:0] r_ref_mem [DEPTH];
    logic [tnnm_pkg::LABEL_W-1:0] r_lbl_mem [ENTRIES];
    logic [tnnm_pkg::VALUE_W-1:0] r_qry_mem [DIM];

    logic [tnnm_pkg::DIST_W-1:0]   r_threshold;
    logic [tnnm_pkg::ACTIVE_W-1:0] r_active;

    logic [tnnm_pkg::IDX_W-1:0] ent_w;
    logic [tnnm_pkg::IDX_W-1:0] ele_w;
    logic [31:0]                wr_lin;
    logic                       ent_ok;
    logic                       ele_ok;
    logic                       load_we;
    logic                       qry_we;
    logic [tnnm_pkg::IDX_W-1:0] act_w;
    logic [tnnm_pkg::IDX_W-1:0] cnt_w;
    logic [tnnm_pkg::IDX_W-1:0] last_ent_w;

    logic [AW-1:0] r_addr;
    logic [EW-1:0] r_ent;
    logic [DW-1:0] r_ele;

    logic                         r_v1, r_v2, r_v3, r_v4;
    logic                         r_f1, r_f2, r_f3, r_f4;
    logic                         r_l1, r_l2, r_l3, r_l4;
    logic [tnnm_pkg::VALUE_W-1:0] r_q_rd;
    logic [tnnm_pkg::VALUE_W-1:0] r_r_rd;
    logic [tnnm_pkg::LABEL_W-1:0] r_lb1, r_lb2, r_lb3, r_lb4;
    logic [tnnm_pkg::VALUE_W-1:0] r_absd;
    logic [tnnm_pkg::SQ_W-1:0]    r_sq;
    logic [tnnm_pkg::DIST_W-1:0]  r_acc;

    logic signed [tnnm_pkg::VALUE_W:0] diff;
    logic [tnnm_pkg::VALUE_W:0]        diff_abs;
    logic [tnnm_pkg::DIST_W:0]         acc_sum;
    logic [tnnm_pkg::DIST_W-1:0]       acc_sat;

    logic [tnnm_pkg::DIST_W-1:0]  r_best;
    logic [tnnm_pkg::LABEL_W-1:0] r_best_lbl;
    logic                         r_found;

    logic                         r_out_valid;
    logic                         r_out_found;
    logic [tnnm_pkg::LABEL_W-1:0] r_out_label;
    logic [tnnm_pkg::DIST_W-1:0]  r_out_dist;

    assign ent_w   = tnnm_pkg::IDX_W'(i_entry_index);
    assign ele_w   = tnnm_pkg::IDX_W'(i_element_index);
    assign wr_lin  = 32'(ent_w) * 32'(DIM) + 32'(ele_w);
    assign ent_ok  = ent_w < tnnm_pkg::IDX_W'(ENTRIES);
    assign ele_ok  = ele_w < tnnm_pkg::IDX_W'(DIM);
    assign load_we = i_cmd.take && (i_item_cmd == tnnm_pkg::CMD_LOAD) && ent_ok && ele_ok;
    assign qry_we  = i_cmd.take && (i_item_cmd == tnnm_pkg::CMD_QUERY) && ele_ok;

    assign act_w      = tnnm_pkg::IDX_W'(r_active);
    assign cnt_w      = (act_w > tnnm_pkg::IDX_W'(ENTRIES)) ? tnnm_pkg::IDX_W'(ENTRIES) : act_w;
    assign last_ent_w = cnt_w - tnnm_pkg::IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= tnnm_pkg::THRESHOLD_RESET;
            r_active    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tnnm_pkg::REG_THRESHOLD: r_threshold <= i_cfg_wdata;
                tnnm_pkg::REG_ACTIVE:    r_active    <= i_cfg_wdata[tnnm_pkg::ACTIVE_W-1:0];
                default: begin
                    r_active <= r_active;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_ref_mem[wr_lin[AW-1:0]] <= i_element_value;
        end
        if (i_cmd.issue) begin
            r_r_rd <= r_ref_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_lbl_mem[ent_w[EW-1:0]] <= i_entry_label;
        end
        if (i_cmd.issue) begin
            r_lb1 <= r_lbl_mem[r_ent];
        end
    end

    always_ff @(posedge i_clk) begin
        if (qry_we) begin
            r_qry_mem[ele_w[DW-1:0]] <= i_element_value;
        end
        if (i_cmd.issue) begin
            r_q_rd <= r_qry_mem[r_ele];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr <= '0;
            r_ent  <= '0;
            r_ele  <= '0;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + AW'(1);
            if (r_ele == ELE_LAST) begin
                r_ele <= '0;
                r_ent <= r_ent + EW'(1);
            end else begin
                r_ele <= r_ele + DW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign diff     = $signed({r_q_rd[tnnm_pkg::VALUE_W-1], r_q_rd})
                    - $signed({r_r_rd[tnnm_pkg::VALUE_W-1], r_r_rd});
    assign diff_abs = diff[tnnm_pkg::VALUE_W] ? 17'(-diff) : 17'(diff);
    assign acc_sum  = {1'b0, r_acc} + (tnnm_pkg::DIST_W + 1)'(r_sq);
    assign acc_sat  = acc_sum[tnnm_pkg::DIST_W] ? tnnm_pkg::DIST_MAX
                                                : acc_sum[tnnm_pkg::DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        r_f1   <= (r_ele == '0);
        r_l1   <= (r_ele == ELE_LAST);
        r_f2   <= r_f1;
        r_l2   <= r_l1;
        r_lb2  <= r_lb1;
        r_absd <= diff_abs[tnnm_pkg::VALUE_W-1:0];
        r_f3   <= r_f2;
        r_l3   <= r_l2;
        r_lb3  <= r_lb2;
        r_sq   <= tnnm_pkg::SQ_W'(r_absd) * tnnm_pkg::SQ_W'(r_absd);
        if (r_v3) begin
            r_f4  <= r_f3;
            r_l4  <= r_l3;
            r_lb4 <= r_lb3;
            r_acc <= r_f3 ? tnnm_pkg::DIST_W'(r_sq) : acc_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_best     <= r_threshold;
            r_best_lbl <= '0;
            r_found    <= 1'b0;
        end else if (r_v4 && r_l4 && (r_acc < r_best)) begin
            r_best     <= r_acc;
            r_best_lbl <= r_lb4;
            r_found    <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_found <= r_found;
            r_out_label <= r_best_lbl;
            r_out_dist  <= r_best;
        end
    end

    assign o_sts.count_zero = (cnt_w == '0);
    assign o_sts.issue_last = (r_ent == last_ent_w[EW-1:0]) && (r_ele == ELE_LAST);
    assign o_sts.pipe_busy  = r_v1 || r_v2 || r_v3 || r_v4;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_found            = r_out_found;
    assign o_match_label      = r_out_label;
    assign o_best_distance_sq = r_out_dist;

endmodule

>>> rtl/core/thresholded_nearest_neighbor_match_core.sv
// Load items and non-final query items are stored while the intake stays open.
// A final query element starts a sweep over min(active_entries, ENTRIES) * DIM elements,
// one element per cycle through the shared subtract-square-accumulate unit, followed
// by pipeline drain and hand-off; no sweep runs when no entries are active.
// Reset (synchronous, active low) clears control state and configuration; stores
// hold no defined contents until written.
// ----------------------------------------------------------------------------
// Thresholded nearest neighbor match core
// Finds the nearest stored reference vector to a query by squared distance.
// ----------------------------------------------------------------------------
module thresholded_nearest_neighbor_match_core #(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned DIM     = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tnnm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tnnm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_index[5:0], element_index[12:6], element_value[28:13],
    // entry_label[36:29], zero fill [39:37]
    input  logic [tnnm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd[0]
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // found[0], match_label[8:1], best_distance_sq[47:9]
    output logic [tnnm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    tnnm_pkg::t_dp_cmd dp_cmd;
    tnnm_pkg::t_dp_sts dp_sts;

    logic                         out_found;
    logic [tnnm_pkg::LABEL_W-1:0] out_label;
    logic [tnnm_pkg::DIST_W-1:0]  out_dist;

    tnnm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_search ((s_axis_tuser == tnnm_pkg::CMD_QUERY) && s_axis_tlast),
        .o_ready  (s_axis_tready),
        .o_cmd    (dp_cmd),
        .i_sts    (dp_sts)
    );

    tnnm_datapath #(
        .ENTRIES (ENTRIES),
        .DIM     (DIM)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_sts              (dp_sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_item_cmd         (s_axis_tuser),
        .i_entry_index      (s_axis_tdata[5:0]),
        .i_element_index    (s_axis_tdata[12:6]),
        .i_element_value    (s_axis_tdata[28:13]),
        .i_entry_label      (s_axis_tdata[36:29]),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_found            (out_found),
        .o_match_label      (out_label),
        .o_best_distance_sq (out_dist)
    );

    assign m_axis_tdata = {out_dist, out_label, out_found};

endmodule

>>> rtl/core/tnnm_checker.sv
// ----------------------------------------------------------------------------
// Nearest neighbor match port checker
// Watches the core's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module tnnm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tuser,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tnnm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_match_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == '0)
        else $error("label present on a result without a match");

    a_plain_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready
        && ((s_axis_tuser == tnnm_pkg::CMD_LOAD) || !s_axis_tlast) |=> s_axis_tready)
        else $error("intake stalled after a store-only transfer");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready
        && (s_axis_tuser == tnnm_pkg::CMD_QUERY) && s_axis_tlast |=> !s_axis_tready)
        else $error("intake open while a search runs");

endmodule

bind thresholded_nearest_neighbor_match_core tnnm_checker u_tnnm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
